/* rtl/rrlp_pkg.sv */
// ----------------------------------------------------------------------------
// rrlp_pkg: shared types and constants for the radar report line parser
// Character codes, the report prefixes, the parse phase type and the request
// and report structures passed between the pipeline stages.
// ----------------------------------------------------------------------------
package rrlp_pkg;

  // Default kept-line length
  localparam int LINE_LIMIT_DEF = 30;

  // Length of the "mov, " / "occ, " prefix
  localparam int PREFIX_LEN = 5;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Magnitude cap and saturated positive value
  localparam logic [31:0] MAG_CAP   = 32'h8000_0000;
  localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

  // Report kinds
  localparam logic KIND_MOV = 1'b0;
  localparam logic KIND_OCC = 1'b1;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_SEEK   = 3'd1,
    PH_BLANK  = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // One received character waiting in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } rrlp_req_t;

  // One finished report
  typedef struct packed {
    logic               valid;
    logic               reading_kind;
    logic signed [31:0] reading_value;
  } rrlp_rep_t;

  // Expected character of "mov, " at a prefix index
  function automatic logic [7:0] mov_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h6D;
      3'd1:    ch = 8'h6F;
      3'd2:    ch = 8'h76;
      3'd3:    ch = 8'h2C;
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

  // Expected character of "occ, " at a prefix index
  function automatic logic [7:0] occ_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h6F;
      3'd1:    ch = 8'h63;
      3'd2:    ch = 8'h63;
      3'd3:    ch = 8'h2C;
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/rrlp_in_stage.sv */
// ----------------------------------------------------------------------------
// rrlp_in_stage: input register
// Captures one received character from the stream and holds it until the
// parse core consumes it.
// ----------------------------------------------------------------------------
module rrlp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               consumed,
  output rrlp_pkg::rrlp_req_t req
);
  import rrlp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // Take a new request when the register is empty or being drained
  assign in_tready = !valid_r || consumed;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (consumed) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the character payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign req.valid   = valid_r;
  assign req.rx_byte = byte_r;

endmodule

/* rtl/rrlp_core.sv */
// ----------------------------------------------------------------------------
// rrlp_core: line parse state
// Updates the line state with one character per cycle while no line end is
// stalled: prefix match, search for the space, blank skip, sign and
// saturating decimal accumulate, and the report decision at the end of a line.
// ----------------------------------------------------------------------------
module rrlp_core #(
  parameter int LINE_LIMIT = rrlp_pkg::LINE_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rrlp_pkg::rrlp_req_t req,
  input  logic                out_free,
  output logic                consumed,
  output rrlp_pkg::rrlp_rep_t rep
);
  import rrlp_pkg::*;

  localparam int PosW = $clog2(LINE_LIMIT + 1);
  localparam logic [PosW-1:0] PosLimit  = PosW'(LINE_LIMIT);
  localparam logic [PosW-1:0] PosPrefix = PosW'(PREFIX_LEN);
  localparam logic [PosW-1:0] PosLast   = PosW'(PREFIX_LEN - 1);

  logic [PosW-1:0] pos_r,   pos_nxt;
  logic [1:0]      flags_r, flags_nxt;
  phase_t          phase_r, phase_nxt;
  logic [31:0]     acc_r,   acc_nxt;
  logic            neg_r,   neg_nxt;
  logic            space_r, space_nxt;

  logic [7:0]  ch;
  logic        is_cr;
  logic        keep;
  logic        in_prefix;
  logic        is_digit;
  logic        is_blank;
  logic        is_sign;
  logic        step;
  logic        report_hit;
  logic [35:0] acc_ext;
  logic [35:0] mul_sum;
  logic [31:0] acc_add;

  // Classify the current character
  assign ch        = req.rx_byte;
  assign is_cr     = (ch == CH_CR);
  assign keep      = (ch != CH_LF) && (pos_r < PosLimit);
  assign in_prefix = (pos_r < PosPrefix);
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_blank  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF);
  assign is_sign   = (ch == CH_PLUS) || (ch == CH_MINUS);

  // Report when a matching line with a space ends
  assign report_hit = req.valid && !is_cr && !keep && (pos_r >= PosPrefix)
                      && (flags_r != 2'b00) && space_r;

  // Stall only a line end whose report cannot be stored yet
  assign consumed = req.valid && (out_free || !report_hit);
  assign step     = consumed && !is_cr;

  // Multiply by ten and add the digit, saturating at the magnitude cap
  assign acc_ext = {4'b0000, acc_r};
  assign mul_sum = (acc_ext << 3) + (acc_ext << 1) + {32'd0, ch[3:0]};
  assign acc_add = (mul_sum > {4'b0000, MAG_CAP}) ? MAG_CAP : mul_sum[31:0];

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      if (!keep) begin
        phase_nxt = PH_PREFIX;
      end else if (in_prefix) begin
        if (pos_r == PosLast) begin
          phase_nxt = PH_SEEK;
        end
      end else begin
        unique case (phase_r)
          PH_SEEK: begin
            if (ch == CH_SPACE) begin
              phase_nxt = PH_BLANK;
            end
          end
          PH_BLANK: begin
            if (is_blank) begin
              phase_nxt = PH_BLANK;
            end else if (is_sign || is_digit) begin
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (!is_digit) begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // Line datapath updates
  always_comb begin
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    space_nxt = space_r;
    if (step) begin
      if (!keep) begin
        pos_nxt   = '0;
        flags_nxt = 2'b11;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        space_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (in_prefix) begin
          if (ch != mov_char(pos_r[2:0])) begin
            flags_nxt[0] = 1'b0;
          end
          if (ch != occ_char(pos_r[2:0])) begin
            flags_nxt[1] = 1'b0;
          end
        end else begin
          case (phase_r)
            PH_SEEK: begin
              if (ch == CH_SPACE) begin
                space_nxt = 1'b1;
              end
            end
            PH_BLANK: begin
              if (!is_blank) begin
                if (is_sign) begin
                  neg_nxt = (ch == CH_MINUS);
                end else if (is_digit) begin
                  acc_nxt = acc_add;
                end
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                acc_nxt = acc_add;
              end
            end
            default: begin
              acc_nxt = acc_r;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      flags_r <= 2'b11;
      phase_r <= PH_PREFIX;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      space_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      space_r <= space_nxt;
    end
  end

  // Form the report: apply the sign, or saturate the positive magnitude
  always_comb begin
    rep.valid        = report_hit && consumed;
    rep.reading_kind = flags_r[0] ? KIND_MOV : KIND_OCC;
    if (neg_r) begin
      rep.reading_value = 32'd0 - acc_r;
    end else if (acc_r[31]) begin
      rep.reading_value = VALUE_MAX;
    end else begin
      rep.reading_value = acc_r;
    end
  end

  // A report comes only from a newline or a byte on a full line
  a_report_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    rep.valid |-> ((req.rx_byte == CH_LF) || (pos_r == PosLimit)))
    else $error("report raised without a line end");

  // A line end clears the line state
  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !keep) |=> ((pos_r == '0) && (phase_r == PH_PREFIX) && (flags_r == 2'b11)))
    else $error("line state not cleared after line end");

  // The kept count never passes the line limit
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosLimit)
    else $error("line position beyond limit");

  // The magnitude never passes its cap
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= MAG_CAP)
    else $error("accumulator beyond cap");

  // Parsing beyond the prefix only once the prefix has been taken in
  a_phase_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_PREFIX) |-> (pos_r >= PosPrefix))
    else $error("parse phase ahead of line position");

endmodule

/* rtl/rrlp_out_stage.sv */
// ----------------------------------------------------------------------------
// rrlp_out_stage: result register
// Holds one finished report on the result stream until it is taken.
// ----------------------------------------------------------------------------
module rrlp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  rrlp_pkg::rrlp_rep_t rep,
  output logic                out_free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,
  output logic [0:0]          out_tuser
);
  import rrlp_pkg::*;

  logic               valid_r;
  logic               valid_nxt;
  logic               kind_r;
  logic signed [31:0] value_r;

  // Room for a new report when empty or being drained
  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (rep.valid) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the report payload
  always_ff @(posedge clk) begin
    if (rep.valid) begin
      kind_r  <= rep.reading_kind;
      value_r <= rep.reading_value;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = value_r;
  assign out_tuser  = kind_r;

endmodule

/* rtl/radar_report_line_parser_top.sv */
// ----------------------------------------------------------------------------
// radar_report_line_parser_top: radar report line parser
// Parses "mov, <n>" and "occ, <n>" lines from a UART byte stream and emits
// one report per matching line.
// ----------------------------------------------------------------------------
// The block takes one received character per clock while no line-ending
// byte is held back (see below); a report shows on out_tvalid once the
// line-ending byte has been taken (the byte sits in the input register while
// the parse core forms the report, and the result register loads it).
// Carriage returns are consumed and ignored. A line ends at a newline, or
// at any byte but CR arriving once LINE_LIMIT characters are kept; that
// byte is not kept. A line starting "mov, " or "occ, " with a space at index
// 5 or later reports the integer after that space (atoi rules, saturated to
// 32-bit signed). If a report is still waiting on the result side, a
// line-ending byte that would report waits in the input register; all
// other bytes keep flowing.
// ----------------------------------------------------------------------------
module radar_report_line_parser_top #(
  parameter int LINE_LIMIT = rrlp_pkg::LINE_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] reading_value (signed)
  output logic [0:0]  out_tuser   // [0] reading_kind
);
  import rrlp_pkg::*;

  rrlp_req_t req;
  rrlp_rep_t rep;
  logic      consumed;
  logic      out_free;

  rrlp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .consumed  (consumed),
    .req       (req)
  );

  rrlp_core #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .out_free (out_free),
    .consumed (consumed),
    .rep      (rep)
  );

  rrlp_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .rep        (rep),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
